// ===== rtl/lru_kv_pkg.sv =====
package lru_kv_pkg;

  // Storage size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CAP_W    = 5;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CAP_W-1:0] cap_t;

  // Request codes
  typedef enum logic {
    REQ_PUT = 1'b0,
    REQ_GET = 1'b1
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_HIT    = 2'd1,
    ST_MISS   = 2'd2,
    ST_ERR    = 2'd3
  } status_t;

  // One cache entry as held in memory
  typedef struct packed {
    idx_t              rank;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } entry_t;

  // Memory access from the controller
  typedef struct packed {
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    idx_t   rd_addr;
  } mem_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

endpackage

// ===== rtl/lru_kv_mem.sv =====
module lru_kv_mem (
  input  logic                 clk,
  input  lru_kv_pkg::mem_req_t req,
  output lru_kv_pkg::entry_t   rd_data
);
  import lru_kv_pkg::*;

  entry_t mem_r [CAPACITY];
  entry_t rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem_r[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lru_kv_ctrl.sv =====
module lru_kv_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_req_type,
  input  logic signed [31:0]      in_key,
  input  logic signed [31:0]      in_value,
  input  lru_kv_pkg::cap_t        cap,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_read_value,
  output lru_kv_pkg::mem_req_t    mem_req,
  input  lru_kv_pkg::entry_t      mem_rd
);
  import lru_kv_pkg::*;

  // Control state
  state_t           state_r, state_nxt;
  cnt_t             count_r, count_nxt;
  cnt_t             idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Item and scan payload
  idx_t             pidx_r, pidx_nxt;
  cnt_t             wp_r, wp_nxt;
  cnt_t             keep_lim_r, keep_lim_nxt;
  req_t             req_r, req_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             hit_r, hit_nxt;
  idx_t             hit_slot_r, hit_slot_nxt;
  idx_t             hit_rank_r, hit_rank_nxt;
  logic [VAL_W-1:0] hit_val_r, hit_val_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;

  cnt_t             eff_cap;
  logic             issue;
  logic             last;

  // Capacity clamped to storage size
  always_comb begin
    if (int'(cap) > CAPACITY) begin
      eff_cap = CNT_W'(CAPACITY);
    end else begin
      eff_cap = CNT_W'(cap);
    end
  end

  assign issue = (idx_r < count_r);
  assign last  = !issue && !pend_r;

  // Next state, memory access and result
  always_comb begin
    entry_t ent;
    ent            = mem_rd;
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = 1'b0;
    pidx_nxt       = pidx_r;
    wp_nxt         = wp_r;
    keep_lim_nxt   = keep_lim_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    hit_rank_nxt   = hit_rank_r;
    hit_val_nxt    = hit_val_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    mem_req         = '0;
    mem_req.rd_addr = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = req_t'(in_req_type);
          key_nxt = in_key;
          val_nxt = in_value;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          if (req_t'(in_req_type) == REQ_PUT && eff_cap == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_ERR;
            out_value_nxt  = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // Walk all live entries looking for the key
      S_SCAN: begin
        if (issue) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end
        if (pend_r && mem_rd.key == key_r) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = pidx_r;
          hit_rank_nxt = mem_rd.rank;
          hit_val_nxt  = mem_rd.value;
        end
        if (last) begin
          idx_nxt = '0;
          wp_nxt  = '0;
          // entries kept on a new insert: all, or the most recent cap-1
          if (count_r >= eff_cap) begin
            keep_lim_nxt = eff_cap - CNT_W'(1);
          end else begin
            keep_lim_nxt = count_r;
          end
          if (!hit_r && req_r == REQ_GET) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_value_nxt  = '0;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_UPDATE;
          end
        end
      end

      // Second pass: promote on hit, age and compact on insert
      S_UPDATE: begin
        if (issue) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          if (hit_r) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pidx_r;
            if (pidx_r == hit_slot_r) begin
              ent.rank = '0;
              if (req_r == REQ_PUT) begin
                ent.value = val_r;
              end
            end else if (ent.rank < hit_rank_r) begin
              ent.rank = ent.rank + IDX_W'(1);
            end
            mem_req.wr_data = ent;
          end else if (CNT_W'(ent.rank) < keep_lim_r) begin
            ent.rank        = ent.rank + IDX_W'(1);
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wp_r[IDX_W-1:0];
            mem_req.wr_data = ent;
            wp_nxt          = wp_r + CNT_W'(1);
          end
        end
        if (last) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          if (hit_r) begin
            if (req_r == REQ_GET) begin
              out_status_nxt = ST_HIT;
              out_value_nxt  = hit_val_r;
            end else begin
              out_status_nxt = ST_STORED;
            end
          end else begin
            // new key goes in behind the kept entries as most recent
            mem_req.wr_en         = 1'b1;
            mem_req.wr_addr       = wp_r[IDX_W-1:0];
            mem_req.wr_data.rank  = '0;
            mem_req.wr_data.key   = key_r;
            mem_req.wr_data.value = val_r;
            count_nxt             = wp_r + CNT_W'(1);
            out_status_nxt        = ST_STORED;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    wp_r         <= wp_nxt;
    keep_lim_r   <= keep_lim_nxt;
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_rank_r   <= hit_rank_nxt;
    hit_val_r    <= hit_val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// LRU key/value cache. Issue a put or get by raising start while busy is low;
// exactly one result follows, shown for a single cycle with out_valid high,
// and the receiver must take it then: there is no backpressure. An item that
// raises busy reads the entry memory through its single read port in one or
// two passes over the N live entries (key search, then recency update or
// compaction); a get miss ends after the key search, and a put at capacity
// zero never raises busy. The result shows in the first cycle with busy low
// again; for a put at capacity zero it shows in the cycle right after the
// item is taken.
// Write cfg_wdata (capacity, clamped to 16) only while busy is low.
module lru_key_value_cache (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_req_type,
  input  logic signed [31:0]  in_key,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_read_value,
  input  logic                cfg_we,
  input  lru_kv_pkg::cap_t    cfg_wdata
);
  import lru_kv_pkg::*;

  cap_t     cap_r;
  mem_req_t mem_req;
  entry_t   mem_rd;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(16);
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  lru_kv_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_value       (in_value),
    .cap            (cap_r),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .mem_req        (mem_req),
    .mem_rd         (mem_rd)
  );

  lru_kv_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

endmodule

// ===== dv/lru_key_value_cache_tb.sv =====
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
  import lru_kv_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int POOL_N       = 24;
  localparam int MAX_LOGGED   = 100;

  typedef struct {
    req_t        op;
    logic [31:0] key;
    logic [31:0] value;
    bit          hold;   // wait for all outstanding results before issuing
  } cache_req_t;

  typedef struct {
    status_t     status;
    logic [31:0] read_value;
  } cache_resp_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic               in_req_type = 1'b0;
  logic signed [31:0] in_key      = '0;
  logic signed [31:0] in_value    = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [31:0] out_read_value;
  logic               cfg_we      = 1'b0;
  cap_t               cfg_wdata   = '0;

  // Items waiting to be issued and results the cache still owes
  cache_req_t  pending_reqs[$];
  cache_resp_t expected_resps[$];
  cache_req_t  cur_req;
  cache_resp_t want_resp;

  // Shadow copy of the cache contents
  logic [31:0] shadow_key [CAPACITY];
  logic [31:0] shadow_val [CAPACITY];
  int unsigned shadow_age [CAPACITY];  // 0 = most recent
  int unsigned live_cnt      = 0;
  int unsigned cap_setting   = 16;

  int unsigned send_idle_pct = 33;
  int unsigned err_cnt       = 0;
  int unsigned stall_cnt     = 0;
  logic [31:0] key_pool [POOL_N];

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Move one live entry to the front of the recency order
  function automatic void bump_to_newest(int unsigned slot);
    int unsigned old_age;
    old_age = shadow_age[slot];
    for (int unsigned i = 0; i < live_cnt; i++)
      if (shadow_age[i] < old_age) shadow_age[i]++;
    shadow_age[slot] = 0;
  endfunction

  // Expected response to one item; updates the shadow cache
  function automatic cache_resp_t predict_resp(cache_req_t rq);
    cache_resp_t rsp;
    int          hit_slot;
    int          victim;
    int unsigned lim;
    int unsigned last;
    rsp.status     = ST_STORED;
    rsp.read_value = '0;
    hit_slot       = -1;
    lim            = (cap_setting > CAPACITY) ? CAPACITY : cap_setting;
    for (int unsigned i = 0; i < live_cnt; i++)
      if (hit_slot < 0 && shadow_key[i] == rq.key) hit_slot = i;

    if (rq.op == REQ_GET) begin
      if (hit_slot >= 0) begin
        bump_to_newest(hit_slot);
        rsp.status     = ST_HIT;
        rsp.read_value = shadow_val[hit_slot];
      end else begin
        rsp.status = ST_MISS;
      end
    end else if (lim == 0) begin
      rsp.status = ST_ERR;
    end else if (hit_slot >= 0) begin
      shadow_val[hit_slot] = rq.value;
      bump_to_newest(hit_slot);
    end else begin
      // drop least recent entries, refilling the hole from the top slot
      while (live_cnt >= lim) begin
        last   = live_cnt - 1;
        victim = -1;
        for (int unsigned i = 0; i < live_cnt; i++)
          if (victim < 0 && shadow_age[i] == last) victim = i;
        if (victim >= 0) begin
          shadow_key[victim] = shadow_key[last];
          shadow_val[victim] = shadow_val[last];
          shadow_age[victim] = shadow_age[last];
        end
        live_cnt = last;
      end
      for (int unsigned i = 0; i < live_cnt; i++) shadow_age[i]++;
      shadow_key[live_cnt] = rq.key;
      shadow_val[live_cnt] = rq.value;
      shadow_age[live_cnt] = 0;
      live_cnt++;
    end
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    // keep the log short when things go badly wrong
    if (err_cnt <= MAX_LOGGED) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void queue_req(req_t op, logic [31:0] k, logic [31:0] v, bit hold);
    cache_req_t rq;
    rq.op    = op;
    rq.key   = k;
    rq.value = v;
    rq.hold  = hold;
    pending_reqs.push_back(rq);
  endfunction

  // Settled check at the falling edge: nothing queued, issued or owed
  task automatic wait_quiet();
    @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_resps.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_capacity(input int unsigned cap);
    wait_quiet();
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= cap_t'(cap);
    cap_setting = cap & 32'h1F;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random items, mostly over a small key set sized to the capacity
  task automatic random_phase(input int unsigned cap, input int unsigned idle_pct,
                              input int unsigned n_items);
    cache_req_t  rq;
    int unsigned span;
    write_capacity(cap);
    send_idle_pct = idle_pct;
    span = ((cap > CAPACITY) ? CAPACITY : cap) + 4;
    for (int unsigned j = 0; j < n_items; j++) begin
      rq.op    = $urandom_range(1) ? REQ_GET : REQ_PUT;
      rq.key   = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span - 1)] : $urandom;
      rq.value = $urandom;
      rq.hold  = ($urandom_range(39) == 0);
      pending_reqs.push_back(rq);
    end
  endtask

  // Driver: hold start until the item is taken, then maybe load the next
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start)
        expected_resps.push_back(predict_resp(cur_req));
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          !(pending_reqs[0].hold && (start || expected_resps.size() != 0))) begin
        cur_req     = pending_reqs.pop_front();
        start       <= 1'b1;
        in_req_type <= cur_req.op;
        in_key      <= cur_req.key;
        in_value    <= cur_req.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_resps.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d value %h",
                                  out_status, out_read_value));
      end else begin
        want_resp = expected_resps.pop_front();
        if (out_status !== want_resp.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_status, want_resp.status));
        if (out_read_value !== want_resp.read_value)
          report_mismatch($sformatf("read_value %h, expected %h",
                                    out_read_value, want_resp.read_value));
      end
    end
  end

  // Watchdog: too long without an item taken or a result seen
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cnt <= 0;
    end else if (stall_cnt == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty cache misses, value ignored on get
    queue_req(REQ_GET, 32'h0000_0000, 32'hAAAA_AAAA, 1'b0);
    // extreme keys and values
    queue_req(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_req(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    queue_req(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_req(REQ_GET, 32'h8000_0000, 32'h5555_5555, 1'b0);
    // put to a present key only updates it
    queue_req(REQ_PUT, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0);
    queue_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    // fill past the size so the least recent entry goes
    for (int i = 1; i <= 13; i++) queue_req(REQ_PUT, i, ~i, 1'b0);
    queue_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);

    // capacity lowered while full: gets still hit, next new put trims
    write_capacity(2);
    queue_req(REQ_GET, 32'd5, 32'h0000_0000, 1'b0);
    queue_req(REQ_PUT, 32'd100, 32'hDEAD_BEEF, 1'b0);
    queue_req(REQ_GET, 32'd13, 32'h0000_0000, 1'b0);

    // capacity zero: put errors, get still looks up
    write_capacity(0);
    queue_req(REQ_PUT, 32'd7, 32'd7, 1'b0);
    queue_req(REQ_GET, 32'd100, 32'h0000_0000, 1'b1);

    // capacity above the maximum is clamped
    write_capacity(31);
    queue_req(REQ_PUT, 32'd200, 32'h0F0F_0F0F, 1'b0);
    queue_req(REQ_GET, 32'd200, 32'h0000_0000, 1'b0);

    // random part, sender idling 33%, then 74%, then never
    random_phase(16, 33, 80);
    random_phase(1, 33, 70);
    random_phase(0, 33, 50);
    random_phase(5, 33, 80);
    random_phase(31, 74, 80);
    random_phase(3, 74, 70);
    random_phase(17, 74, 70);
    random_phase(9, 74, 80);
    random_phase(2, 0, 70);
    random_phase(16, 0, 100);
    random_phase(8, 0, 70);

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
